@@ design/script_keyword_flag_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// script keyword flag scanner assertion macros
// shared assertion forms, clocked on i_clk and quiet while in reset
// ----------------------------------------------------------------------------
`ifndef SCRIPT_KEYWORD_FLAG_SCANNER_ASSERT_SVH
`define SCRIPT_KEYWORD_FLAG_SCANNER_ASSERT_SVH

// same-cycle implication
`define SKFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/skfs_pkg.sv @@
// ----------------------------------------------------------------------------
// script keyword flag scanner package
// window size, keyword table and character helpers
// ----------------------------------------------------------------------------
package skfs_pkg;

    localparam int unsigned WIN_DEPTH = 23;
    localparam int unsigned KW_COUNT  = 7;

    typedef logic [WIN_DEPTH-1:0][7:0] t_win;
    typedef logic [4:0]                t_cnt;
    typedef logic [2:0]                t_routine;
    typedef logic [5:0]                t_flags;
    typedef logic [WIN_DEPTH*8-1:0]    t_kw_text;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // common prefix of the hook names
    localparam logic [23:0] KW_PREFIX = "pe_";

    // first character sits in the top used byte of each entry
    localparam t_kw_text KW_STR [KW_COUNT] = '{
        t_kw_text'({KW_PREFIX, "http_recv_request"}),
        t_kw_text'({KW_PREFIX, "http_send_response"}),
        t_kw_text'({KW_PREFIX, "om_send_request"}),
        t_kw_text'({KW_PREFIX, "om_recv_response"}),
        t_kw_text'({KW_PREFIX, "cl_http_recv_request"}),
        t_kw_text'("getparam"),
        t_kw_text'("setaction")
    };

    localparam t_cnt KW_LEN [KW_COUNT] = '{
        5'd20, 5'd21, 5'd18, 5'd19, 5'd23, 5'd8, 5'd9
    };

    // zero marks a word that sets a flag instead of the routine
    localparam t_routine KW_ROUTINE [KW_COUNT] = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0
    };

    function automatic logic [7:0] f_fold(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return 8'(c + CH_CASE);
        end
        return c;
    endfunction

    function automatic logic f_kw_hit(input t_win win, input t_cnt fill, input int unsigned k);
        logic        hit;
        int unsigned len;
        len = 32'(KW_LEN[k]);
        hit = (32'(fill) >= len);
        for (int unsigned i = 0; i < WIN_DEPTH; i++) begin
            if (i < len) begin
                if (f_fold(win[i]) != KW_STR[k][(len-1-i)*8 +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

@@ design/script_keyword_flag_scanner.sv @@
// ----------------------------------------------------------------------------
// script keyword flag scanner
// folds case, skips comments and quoted text, tracks hook routines and
// collects a flag bit per routine that calls getparam or setaction
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the script streams in
// each byte is judged from a 23-byte window, 22 words after it arrives
// after the final byte the window drains one byte a cycle; the result register
// loads once the window is empty and the output is free, input held off
// i_rst_n is synchronous, active low, and clears all control state
`include "script_keyword_flag_scanner_assert.svh"

module script_keyword_flag_scanner
    import skfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_script_byte,
    input  logic       i_end_of_script,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_routine_flags
);

    t_win     r_win,      n_win;
    t_cnt     r_fill,     n_fill;
    t_cnt     r_skip,     n_skip;
    logic     r_comment,  n_comment;
    logic     r_quote,    n_quote;
    t_routine r_routine,  n_routine;
    t_flags   r_flags,    n_flags;
    logic     r_drain,    n_drain;
    logic     r_out_valid, n_out_valid;
    t_flags   r_out_flags, n_out_flags;

    t_win     w_win;
    t_cnt     w_fill;
    logic     w_accept;
    logic     w_out_free;
    logic     w_judge;
    logic     w_emit;
    logic     w_found;
    logic [7:0] w_head;
    logic [KW_COUNT-1:0] w_hit;

    assign o_in_ready      = !r_drain;
    assign o_out_valid     = r_out_valid;
    assign o_routine_flags = r_out_flags;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = r_drain && (r_fill == '0) && w_out_free;

    // window as seen by the judge: the accepted word lands at the fill point
    always_comb begin
        w_win  = r_win;
        w_fill = r_fill;
        if (w_accept) begin
            for (int unsigned i = 0; i < WIN_DEPTH; i++) begin
                if (5'(i) == r_fill) begin
                    w_win[i] = i_script_byte;
                end
            end
            w_fill = 5'(r_fill + 5'd1);
        end
    end

    assign w_judge = w_accept ? ((32'(w_fill) == WIN_DEPTH) || i_end_of_script)
                              : (r_drain && (r_fill != '0));
    assign w_head  = w_win[0];

    always_comb begin
        for (int unsigned k = 0; k < KW_COUNT; k++) begin
            w_hit[k] = f_kw_hit(w_win, w_fill, k);
        end
    end

    always_comb begin
        n_win       = w_win;
        n_fill      = w_fill;
        n_skip      = r_skip;
        n_comment   = r_comment;
        n_quote     = r_quote;
        n_routine   = r_routine;
        n_flags     = r_flags;
        n_drain     = r_drain;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_flags = r_out_flags;
        w_found     = 1'b0;

        if (w_accept && i_end_of_script) begin
            n_drain = 1'b1;
        end

        if (w_judge) begin
            if (r_skip != '0) begin
                n_skip = 5'(r_skip - 5'd1);
            end else if (r_comment) begin
                if (w_head == CH_NEWLINE) begin
                    n_comment = 1'b0;
                end
            end else if (r_quote) begin
                if (w_head == CH_QUOTE) begin
                    n_quote = 1'b0;
                end
            end else if (w_head == CH_HASH) begin
                n_comment = 1'b1;
            end else if (w_head == CH_QUOTE) begin
                n_quote = 1'b1;
            end else begin
                // keywords are disjoint, but keep table order as priority
                for (int unsigned k = 0; k < KW_COUNT; k++) begin
                    if (w_hit[k] && !w_found) begin
                        w_found = 1'b1;
                        n_skip  = KW_LEN[k];
                        if (KW_ROUTINE[k] != '0) begin
                            n_routine = KW_ROUTINE[k];
                        end else begin
                            n_flags = r_flags | 6'(6'd1 << r_routine);
                        end
                    end
                end
            end

            for (int unsigned i = 0; i < WIN_DEPTH - 1; i++) begin
                n_win[i] = w_win[i+1];
            end
            n_win[WIN_DEPTH-1] = '0;
            n_fill = 5'(w_fill - 5'd1);
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_flags = r_flags;
            n_drain     = 1'b0;
            n_fill      = '0;
            n_skip      = '0;
            n_comment   = 1'b0;
            n_quote     = 1'b0;
            n_routine   = '0;
            n_flags     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_skip      <= '0;
            r_comment   <= 1'b0;
            r_quote     <= 1'b0;
            r_routine   <= '0;
            r_flags     <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_skip      <= n_skip;
            r_comment   <= n_comment;
            r_quote     <= n_quote;
            r_routine   <= n_routine;
            r_flags     <= n_flags;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_out_flags <= n_out_flags;
    end

    `SKFS_ASSERT_NOW(a_fill_bound, 1'b1, 32'(r_fill) <= WIN_DEPTH, "window fill out of range")
    `SKFS_ASSERT_NOW(a_mode_excl, 1'b1, !(r_comment && r_quote), "comment and quote both open")
    `SKFS_ASSERT_NEXT(a_last_drains, w_accept && i_end_of_script, r_drain,
                      "final word did not start drain")
    `SKFS_ASSERT_NEXT(a_steady_fill, w_accept && !i_end_of_script && (r_fill == 5'd22),
                      r_fill == 5'd22, "window fill not steady while streaming")
    `SKFS_ASSERT_NEXT(a_emit_clears, w_emit,
                      o_out_valid && !r_drain && (r_flags == '0) && (r_routine == '0),
                      "result did not clear scan state")

endmodule

@@ test/flag_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag scoreboard
// predicts the routine flag word of each script from the bytes accepted by
// the scanner and compares it with the words the scanner returns
// ----------------------------------------------------------------------------
package flag_scoreboard_pkg;

    import skfs_pkg::t_flags;
    import skfs_pkg::t_routine;

    localparam int WINDOW_BYTES = 23;
    localparam int NUM_WORDS    = 7;

    localparam logic [7:0] C_HASH    = 8'h23;
    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_NEWLINE = 8'h0A;

    // common prefix of the hook names
    localparam string HOOK_PREFIX = "pe_";

    typedef enum int {
        WORD_HTTP_RECV_REQ,
        WORD_HTTP_SEND_RESP,
        WORD_OM_SEND_REQ,
        WORD_OM_RECV_RESP,
        WORD_CL_HTTP_RECV_REQ,
        WORD_GETPARAM,
        WORD_SETACTION
    } t_word;

    function automatic string word_text(t_word w);
        case (w)
            WORD_HTTP_RECV_REQ:    return {HOOK_PREFIX, "http_recv_request"};
            WORD_HTTP_SEND_RESP:   return {HOOK_PREFIX, "http_send_response"};
            WORD_OM_SEND_REQ:      return {HOOK_PREFIX, "om_send_request"};
            WORD_OM_RECV_RESP:     return {HOOK_PREFIX, "om_recv_response"};
            WORD_CL_HTTP_RECV_REQ: return {HOOK_PREFIX, "cl_http_recv_request"};
            WORD_GETPARAM:         return "getparam";
            default:               return "setaction";
        endcase
    endfunction

    // zero for the words that set a flag bit
    function automatic t_routine word_routine(t_word w);
        case (w)
            WORD_HTTP_RECV_REQ:    return 3'd1;
            WORD_HTTP_SEND_RESP:   return 3'd2;
            WORD_OM_SEND_REQ:      return 3'd3;
            WORD_OM_RECV_RESP:     return 3'd4;
            WORD_CL_HTTP_RECV_REQ: return 3'd5;
            default:               return 3'd0;
        endcase
    endfunction

    class flag_scoreboard;
        logic [7:0] window [WINDOW_BYTES];
        int         fill;
        int         skip;
        bit         in_comment;
        bit         in_quote;
        t_routine   routine;
        t_flags     flags;
        t_flags     expected_flags [$];
        int         err_count;

        function new();
            err_count = 0;
            clear();
        endfunction

        function void clear();
            foreach (window[i]) window[i] = 8'h00;
            fill       = 0;
            skip       = 0;
            in_comment = 1'b0;
            in_quote   = 1'b0;
            routine    = 3'd0;
            flags      = 6'd0;
        endfunction

        function logic [7:0] fold_case(logic [7:0] c);
            if (c >= "A" && c <= "Z") begin
                return 8'(c + 8'h20);
            end
            return c;
        endfunction

        function bit word_at_head(t_word w);
            string s;
            s = word_text(w);
            if (s.len() > fill) begin
                return 1'b0;
            end
            for (int i = 0; i < s.len(); i++) begin
                if (fold_case(window[i]) != 8'(s[i])) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // decide the oldest byte in the window, then drop it
        function void judge_head();
            logic [7:0] c;
            t_word      w;
            c = window[0];
            if (skip > 0) begin
                skip--;
            end else if (in_comment) begin
                if (c == C_NEWLINE) in_comment = 1'b0;
            end else if (in_quote) begin
                if (c == C_QUOTE) in_quote = 1'b0;
            end else if (c == C_HASH) begin
                in_comment = 1'b1;
            end else if (c == C_QUOTE) begin
                in_quote = 1'b1;
            end else begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    w = t_word'(k);
                    if (word_at_head(w)) begin
                        if (word_routine(w) != 3'd0) begin
                            routine = word_routine(w);
                        end else begin
                            flags[routine] = 1'b1;
                        end
                        // rest of the keyword plus the byte after it
                        skip = word_text(w).len();
                        break;
                    end
                end
            end
            if (fill > 0) begin
                for (int i = 0; i < WINDOW_BYTES - 1; i++) window[i] = window[i + 1];
                window[WINDOW_BYTES - 1] = 8'h00;
                fill--;
            end
        endfunction

        function void scan_byte(logic [7:0] b, logic last);
            if (fill >= WINDOW_BYTES) judge_head();
            window[fill] = b;
            fill++;
            if (last) begin
                while (fill > 0) judge_head();
                expected_flags.push_back(flags);
                clear();
            end else if (fill >= WINDOW_BYTES) begin
                judge_head();
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            err_count++;
        endtask

        task check_flags(t_flags got);
            t_flags want;
            if (expected_flags.size() == 0) begin
                report($sformatf("routine_flags %02h with no script pending", got));
                return;
            end
            want = expected_flags.pop_front();
            if (got !== want) begin
                report($sformatf("routine_flags %02h, predicted %02h", got, want));
            end
        endtask
    endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script keyword flag scanner testbench
// streams directed and randomly built scripts through the scanner with
// random gaps and stalls on both sides, and checks every flag word against
// a predictor fed with the accepted bytes
// ----------------------------------------------------------------------------
module tb_top;

    import skfs_pkg::*;
    import flag_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_script_byte   = 8'h00;
    logic       i_end_of_script = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready     = 1'b0;
    logic [5:0] o_routine_flags;

    flag_scoreboard sb;
    logic [7:0]     script_q [$];
    int             bytes_sent   = 0;
    int             cycles       = 0;
    bit             sender_calm  = 1'b0;
    bit             hold_request = 1'b0;

    script_keyword_flag_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_script_byte   (i_script_byte),
        .i_end_of_script (i_end_of_script),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_routine_flags (o_routine_flags)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("script_keyword_flag_scanner test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // script building
    // ------------------------------------------------------------------
    function automatic void put_text(string s, bit mixed);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = 8'(s[i]);
            if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
                c = 8'(c - 8'h20);
            end
            script_q.push_back(c);
        end
    endfunction

    function automatic void add_separator();
        string punct;
        int    pick;
        punct = " (;\n";
        pick  = $urandom_range(0, 99);
        if (pick < 60) begin
            script_q.push_back(8'(punct[$urandom_range(0, 3)]));
        end else if (pick >= 75) begin
            script_q.push_back(8'($urandom_range(0, 255)));
        end
        // otherwise the next token follows directly and loses its first byte
    endfunction

    function automatic void add_token();
        int         pick;
        string      s;
        logic [7:0] opener;
        logic [7:0] closer;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            put_text(word_text(t_word'($urandom_range(0, 4))), $urandom_range(0, 99) < 30);
            add_separator();
        end else if (pick < 45) begin
            put_text(word_text(t_word'($urandom_range(5, 6))), $urandom_range(0, 99) < 30);
            add_separator();
        end else if (pick < 69) begin
            // comment or quoted text, often hiding a keyword, sometimes unclosed
            opener = (pick < 57) ? C_HASH : C_QUOTE;
            closer = (pick < 57) ? C_NEWLINE : C_QUOTE;
            script_q.push_back(opener);
            repeat ($urandom_range(0, 4)) script_q.push_back(8'($urandom_range("a", "z")));
            if ($urandom_range(0, 9) < 4) begin
                put_text(word_text(t_word'($urandom_range(0, NUM_WORDS - 1))), 1'b0);
            end
            if ($urandom_range(0, 9) != 0) script_q.push_back(closer);
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) script_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            // near miss: cut short or one letter wrong
            s = word_text(t_word'($urandom_range(0, NUM_WORDS - 1)));
            if ($urandom_range(0, 1) == 1) begin
                s = s.substr(0, $urandom_range(0, s.len() - 2));
            end else begin
                s[$urandom_range(0, s.len() - 1)] = "x";
            end
            put_text(s, $urandom_range(0, 99) < 30);
        end
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        bit hs;
        i_in_valid      <= 1'b1;
        i_script_byte   <= b;
        i_end_of_script <= last;
        do begin
            @(negedge i_clk);
            hs = o_in_ready;
            @(posedge i_clk);
        end while (!hs);
        sb.scan_byte(b, last);
        bytes_sent++;
        if (!sender_calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_script();
        for (int i = 0; i < script_q.size(); i++) begin
            send_byte(script_q[i], i == script_q.size() - 1);
        end
        script_q.delete();
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (sb.expected_flags.size() != 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver
    // ------------------------------------------------------------------
    initial begin
        bit     take;
        t_flags seen;
        int     hold_left;
        bit     hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            take = o_out_valid && i_out_ready;
            seen = o_routine_flags;
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            @(posedge i_clk);
            if (take) sb.check_flags(seen);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (sender_calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int scripts;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero byte, top byte, keyword ending on the last byte,
        // keyword cut by the end, hash inside quoted text
        script_q.push_back(8'h00);
        send_script();
        script_q.push_back(8'hFF);
        send_script();
        put_text("GetParam", 1'b0);
        send_script();
        put_text("setactio", 1'b0);
        send_script();
        put_text("\"#\"", 1'b0);
        send_script();

        scripts = 0;
        while (bytes_sent < 650 || scripts < 24) begin
            scripts++;
            sender_calm = (scripts >= 14 && scripts < 21);
            if (scripts == 6) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            if (scripts == 10) begin
                // short scripts pile up behind a stalled receiver
                hold_request = 1'b1;
                repeat (10) begin
                    repeat ($urandom_range(1, 3)) script_q.push_back(8'($urandom_range(0, 255)));
                    send_script();
                end
            end
            repeat ($urandom_range(1, 4)) add_token();
            send_script();
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (sb.err_count == 0) begin
            $display("script_keyword_flag_scanner test passed");
        end else begin
            $display("script_keyword_flag_scanner test failed");
        end
        $finish;
    end

endmodule
